>>> rtl/rskd_pkg.sv
// Shared types and constants for the small RSA key derivation block.
// Used by the controller, the datapath, the arithmetic units and the top level.
// No dependencies.
`default_nettype none

package rskd_pkg;

   // Width of a factor after stepping up to the next prime (65537 needs 17 bits).
   localparam int FACTOR_W = 17;
   // Trial divisor and its square during a primality test.
   localparam int IDX_W = 17;
   localparam int SQ_W = 33;
   // Signed Bezout coefficients of the extended Euclid loop.
   localparam int T_W = 33;
   // Iteration counter of the restoring divider.
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic [15:0] prime_p;
      logic [15:0] prime_q;
      logic [31:0] search_start;
   } req_type;

   typedef struct packed {
      logic [31:0] modulus;
      logic [31:0] totient_value;
      logic [31:0] public_exponent;
      logic [31:0] private_exponent;
      logic        key_found;
   } rsp_type;

   // Operand pairs for the shared divider.
   typedef enum logic [1:0] {
      DIV_CAND_BY_IDX,
      DIV_PHI_BY_CAND,
      DIV_START_BY_PHI,
      DIV_R_BY_NR
   } div_sel_type;

   // What the running primality test is for.
   typedef enum logic [1:0] {
      CTX_P,
      CTX_Q,
      CTX_E
   } ctx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PT_LOOP,
      ST_PT_DIV,
      ST_NPHI,
      ST_PHI_CHECK,
      ST_RES_WAIT,
      ST_E_CHECK,
      ST_E_DIV,
      ST_INV_LOOP,
      ST_INV_DIV,
      ST_INV_MUL,
      ST_INV_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load_in;
      logic        set_p;
      logic        set_q;
      logic        cand_inc;
      logic        pt_init;
      logic        pt_next;
      logic        calc_nphi;
      logic        cand_from_rem;
      logic        inv_init;
      logic        inv_update;
      logic        inv_finish;
      logic        div_start;
      div_sel_type div_sel;
      logic        mul_start;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic cand_lt2;
      logic sq_gt_cand;
      logic div_busy;
      logic div_done;
      logic rem_zero;
      logic phi_lt2;
      logic cand_ge_phi;
      logic nr_zero;
      logic mul_done;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/rsa_small_key_derivation_core.sv
// Small RSA key derivation: one key per request, one request in flight at a time.
// Latency depends on the data: trial divisions and extended Euclid steps all run on the
// shared 32-bit restoring divider.
// A new request is taken only when idle; a finished key may wait in the output register.
// Synchronous active-high reset returns to idle with the prime advance mode enabled.
`default_nettype none

module rsa_small_key_derivation_core #(
   parameter int PRIME_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rskd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rskd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data
);

   rskd_pkg::cmd_type  cmd;
   rskd_pkg::stat_type stat;

   rskd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

   rskd_datapath #(
      .PRIME_BITS (PRIME_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/rskd_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on rskd_pkg for the iteration counter width.
`default_nettype none

module rskd_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [rskd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]                    quo_ff, quo_in;
   logic [31:0]                    rem_ff, rem_in;
   logic [31:0]                    dvs_ff, dvs_in;
   logic [32:0]                    rem_sh;
   logic [32:0]                    diff;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[31]};
      diff    = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + rskd_pkg::DIV_CNT_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/rskd_mul.sv
// Shift-and-add multiplier: unsigned 32-bit times signed coefficient, modulo 2^T_W.
// Depends on rskd_pkg for the coefficient width.
`default_nettype none

module rskd_mul (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [31:0]                    multiplier,
   input  wire logic signed [rskd_pkg::T_W-1:0] multiplicand,
   output logic                                done,
   output logic signed [rskd_pkg::T_W-1:0]      product
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [31:0]                        mlr_ff, mlr_in;
   logic signed [rskd_pkg::T_W-1:0]    mcd_ff, mcd_in;
   logic signed [rskd_pkg::T_W-1:0]    acc_ff, acc_in;

   // Consume one multiplier bit per cycle; stop as soon as no set bits remain.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mlr_in  = mlr_ff;
      mcd_in  = mcd_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         mlr_in  = multiplier;
         mcd_in  = multiplicand;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (mlr_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (mlr_ff[0]) begin
               acc_in = acc_ff + mcd_ff;
            end
            mcd_in = mcd_ff <<< 1;
            mlr_in = mlr_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mlr_ff <= mlr_in;
      mcd_ff <= mcd_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

>>> rtl/rskd_datapath.sv
// Datapath: factor, totient, candidate and Euclid registers plus the result register.
// Depends on rskd_pkg, rskd_div and rskd_mul.
`default_nettype none

module rskd_datapath #(
   parameter int PRIME_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rskd_pkg::cmd_type cmd,
   output rskd_pkg::stat_type     stat,
   input  wire rskd_pkg::req_type req_data,
   output rskd_pkg::rsp_type      rsp_data
);

   // Only the low PRIME_BITS bits of each factor are used.
   localparam logic [15:0] FMASK = 16'((33'd1 << PRIME_BITS) - 33'd1);

   logic [rskd_pkg::FACTOR_W-1:0] p_ff, p_in;
   logic [rskd_pkg::FACTOR_W-1:0] q_ff, q_in;
   logic [31:0]                   start_ff, start_in;
   logic [31:0]                   cand_ff, cand_in;
   logic [rskd_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [rskd_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [31:0]                   n_ff, n_in;
   logic [31:0]                   phi_ff, phi_in;
   logic [31:0]                   r_ff, r_in;
   logic [31:0]                   nr_ff, nr_in;
   logic signed [rskd_pkg::T_W-1:0] t_ff, t_in;
   logic signed [rskd_pkg::T_W-1:0] nt_ff, nt_in;
   logic signed [rskd_pkg::T_W-1:0] t_pos;
   logic [31:0]                   e_ff, e_in;
   logic [31:0]                   d_ff, d_in;
   logic                          found_ff, found_in;
   rskd_pkg::rsp_type             rsp_ff, rsp_in;
   logic [31:0]                   p_ext, q_ext;

   logic [31:0] div_a, div_b, div_quot, div_rem;
   logic        div_busy, div_done;
   logic signed [rskd_pkg::T_W-1:0] mul_prod;
   logic        mul_done;

   // Divider operand selection.
   always_comb begin
      case (cmd.div_sel)
         rskd_pkg::DIV_CAND_BY_IDX: begin
            div_a = cand_ff;
            div_b = 32'(idx_ff);
         end
         rskd_pkg::DIV_PHI_BY_CAND: begin
            div_a = phi_ff;
            div_b = cand_ff;
         end
         rskd_pkg::DIV_START_BY_PHI: begin
            div_a = start_ff;
            div_b = phi_ff;
         end
         default: begin
            div_a = r_ff;
            div_b = nr_ff;
         end
      endcase
   end

   rskd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // The Euclid step multiplies the fresh quotient by the newer coefficient.
   rskd_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.mul_start),
      .multiplier   (div_quot),
      .multiplicand (nt_ff),
      .done         (mul_done),
      .product      (mul_prod)
   );

   // Register updates driven by the controller commands.
   always_comb begin
      p_ext    = 32'(p_ff);
      q_ext    = 32'(q_ff);
      t_pos    = t_ff + rskd_pkg::T_W'(phi_ff);
      p_in     = p_ff;
      q_in     = q_ff;
      start_in = start_ff;
      cand_in  = cand_ff;
      idx_in   = idx_ff;
      sq_in    = sq_ff;
      n_in     = n_ff;
      phi_in   = phi_ff;
      r_in     = r_ff;
      nr_in    = nr_ff;
      t_in     = t_ff;
      nt_in    = nt_ff;
      e_in     = e_ff;
      d_in     = d_ff;
      found_in = found_ff;
      rsp_in   = rsp_ff;

      if (cmd.load_in) begin
         p_in     = rskd_pkg::FACTOR_W'(req_data.prime_p & FMASK);
         q_in     = rskd_pkg::FACTOR_W'(req_data.prime_q & FMASK);
         start_in = req_data.search_start;
         cand_in  = 32'(req_data.prime_p & FMASK);
         e_in     = '0;
         d_in     = '0;
         found_in = 1'b0;
      end
      if (cmd.set_p) begin
         p_in    = cand_ff[rskd_pkg::FACTOR_W-1:0];
         cand_in = 32'(q_ff);
      end
      if (cmd.set_q) begin
         q_in = cand_ff[rskd_pkg::FACTOR_W-1:0];
      end
      if (cmd.cand_inc) begin
         cand_in = cand_ff + 32'd1;
      end
      if (cmd.cand_from_rem) begin
         cand_in = div_rem;
      end

      // Trial divisor and its square advance together.
      if (cmd.pt_init) begin
         idx_in = rskd_pkg::IDX_W'(2);
         sq_in  = rskd_pkg::SQ_W'(4);
      end
      if (cmd.pt_next) begin
         idx_in = idx_ff + rskd_pkg::IDX_W'(1);
         sq_in  = sq_ff + rskd_pkg::SQ_W'({idx_ff, 1'b1});
      end

      // Modulus and totient, both taken modulo 2^32.
      if (cmd.calc_nphi) begin
         n_in   = 32'(p_ext * q_ext);
         phi_in = 32'((p_ext - 32'd1) * (q_ext - 32'd1));
      end

      // Extended Euclid over (phi, e).
      if (cmd.inv_init) begin
         e_in     = cand_ff;
         found_in = 1'b1;
         r_in     = phi_ff;
         nr_in    = cand_ff;
         t_in     = '0;
         nt_in    = rskd_pkg::T_W'(1);
      end
      if (cmd.inv_update) begin
         t_in  = nt_ff;
         nt_in = t_ff - mul_prod;
         r_in  = nr_ff;
         nr_in = div_rem;
      end
      if (cmd.inv_finish) begin
         if (r_ff != 32'd1) begin
            d_in = '0;
         end else if (t_ff < 0) begin
            d_in = t_pos[31:0];
         end else begin
            d_in = t_ff[31:0];
         end
      end

      if (cmd.out_load) begin
         rsp_in.modulus          = n_ff;
         rsp_in.totient_value    = phi_ff;
         rsp_in.public_exponent  = e_ff;
         rsp_in.private_exponent = d_ff;
         rsp_in.key_found        = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      q_ff     <= q_in;
      start_ff <= start_in;
      cand_ff  <= cand_in;
      idx_ff   <= idx_in;
      sq_ff    <= sq_in;
      n_ff     <= n_in;
      phi_ff   <= phi_in;
      r_ff     <= r_in;
      nr_ff    <= nr_in;
      t_ff     <= t_in;
      nt_ff    <= nt_in;
      e_ff     <= e_in;
      d_ff     <= d_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   // Status back to the controller.
   always_comb begin
      stat.cand_lt2    = (cand_ff < 32'd2);
      stat.sq_gt_cand  = (sq_ff > rskd_pkg::SQ_W'(cand_ff));
      stat.div_busy    = div_busy;
      stat.div_done    = div_done;
      stat.rem_zero    = (div_rem == '0);
      stat.phi_lt2     = (phi_ff < 32'd2);
      stat.cand_ge_phi = (cand_ff >= phi_ff);
      stat.nr_zero     = (nr_ff == '0);
      stat.mul_done    = mul_done;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/rskd_ctrl.sv
// Controller: sequences prime tests, the exponent search and the inverse, and owns
// the configuration register and the result valid flag. Depends on rskd_pkg.
`default_nettype none

module rskd_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_wr_data,
   output rskd_pkg::cmd_type  cmd,
   input  wire rskd_pkg::stat_type stat
);

   rskd_pkg::state_type state_ff, state_in;
   rskd_pkg::ctx_type   ctx_ff, ctx_in;
   logic                adv_ff, adv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                pt_pass;
   logic                pt_fail;

   // Configuration register.
   assign adv_in = csr_wr_en ? csr_wr_data : adv_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      cmd      = '0;
      pt_pass  = 1'b0;
      pt_fail  = 1'b0;

      unique case (state_ff)
         rskd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               if (adv_ff) begin
                  cmd.pt_init = 1'b1;
                  ctx_in      = rskd_pkg::CTX_P;
                  state_in    = rskd_pkg::ST_PT_LOOP;
               end else begin
                  state_in = rskd_pkg::ST_NPHI;
               end
            end
         end
         rskd_pkg::ST_PT_LOOP: begin
            if (stat.cand_lt2) begin
               pt_fail = 1'b1;
            end else if (stat.sq_gt_cand) begin
               pt_pass = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = rskd_pkg::DIV_CAND_BY_IDX;
               state_in      = rskd_pkg::ST_PT_DIV;
            end
         end
         rskd_pkg::ST_PT_DIV: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  pt_fail = 1'b1;
               end else begin
                  cmd.pt_next = 1'b1;
                  state_in    = rskd_pkg::ST_PT_LOOP;
               end
            end
         end
         rskd_pkg::ST_NPHI: begin
            cmd.calc_nphi = 1'b1;
            state_in      = rskd_pkg::ST_PHI_CHECK;
         end
         rskd_pkg::ST_PHI_CHECK: begin
            if (stat.phi_lt2) begin
               state_in = rskd_pkg::ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = rskd_pkg::DIV_START_BY_PHI;
               state_in      = rskd_pkg::ST_RES_WAIT;
            end
         end
         rskd_pkg::ST_RES_WAIT: begin
            if (stat.div_done) begin
               cmd.cand_from_rem = 1'b1;
               state_in          = rskd_pkg::ST_E_CHECK;
            end
         end
         rskd_pkg::ST_E_CHECK: begin
            if (stat.cand_ge_phi) begin
               state_in = rskd_pkg::ST_DONE;
            end else if (stat.cand_lt2) begin
               cmd.cand_inc = 1'b1;
            end else begin
               ctx_in      = rskd_pkg::CTX_E;
               cmd.pt_init = 1'b1;
               state_in    = rskd_pkg::ST_PT_LOOP;
            end
         end
         rskd_pkg::ST_E_DIV: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  cmd.cand_inc = 1'b1;
                  state_in     = rskd_pkg::ST_E_CHECK;
               end else begin
                  cmd.inv_init = 1'b1;
                  state_in     = rskd_pkg::ST_INV_LOOP;
               end
            end
         end
         rskd_pkg::ST_INV_LOOP: begin
            if (stat.nr_zero) begin
               state_in = rskd_pkg::ST_INV_FIN;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = rskd_pkg::DIV_R_BY_NR;
               state_in      = rskd_pkg::ST_INV_DIV;
            end
         end
         rskd_pkg::ST_INV_DIV: begin
            if (stat.div_done) begin
               cmd.mul_start = 1'b1;
               state_in      = rskd_pkg::ST_INV_MUL;
            end
         end
         rskd_pkg::ST_INV_MUL: begin
            if (stat.mul_done) begin
               cmd.inv_update = 1'b1;
               state_in       = rskd_pkg::ST_INV_LOOP;
            end
         end
         rskd_pkg::ST_INV_FIN: begin
            cmd.inv_finish = 1'b1;
            state_in       = rskd_pkg::ST_DONE;
         end
         rskd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = rskd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rskd_pkg::ST_IDLE;
         end
      endcase

      // Outcome of a primality test, by what it was run for.
      if (pt_pass) begin
         unique case (ctx_ff)
            rskd_pkg::CTX_P: begin
               cmd.set_p   = 1'b1;
               cmd.pt_init = 1'b1;
               ctx_in      = rskd_pkg::CTX_Q;
               state_in    = rskd_pkg::ST_PT_LOOP;
            end
            rskd_pkg::CTX_Q: begin
               cmd.set_q = 1'b1;
               state_in  = rskd_pkg::ST_NPHI;
            end
            default: begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = rskd_pkg::DIV_PHI_BY_CAND;
               state_in      = rskd_pkg::ST_E_DIV;
            end
         endcase
      end
      if (pt_fail) begin
         cmd.cand_inc = 1'b1;
         unique case (ctx_ff) inside
            rskd_pkg::CTX_P, rskd_pkg::CTX_Q: begin
               cmd.pt_init = 1'b1;
               state_in    = rskd_pkg::ST_PT_LOOP;
            end
            default: begin
               state_in = rskd_pkg::ST_E_CHECK;
            end
         endcase
      end
   end

   // The result register holds until the consumer takes the transfer.
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rskd_pkg::ST_IDLE;
         ctx_ff       <= rskd_pkg::CTX_P;
         adv_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         adv_ff       <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != rskd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The divider is only started when it is free.
   a_div_free : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider started while busy");

   // The multiplier consumes a quotient in the cycle it becomes available.
   a_mul_after_div : assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> stat.div_done)
      else $error("multiplier started without a fresh quotient");

   // A new result only appears after the sequence has finished.
   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rskd_pkg::ST_DONE)
      else $error("result raised outside the finish state");

   // Leaving the finish state always loads the result register.
   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rskd_pkg::ST_DONE && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("finished key not presented");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for rsa_small_key_derivation_core: directed and random key requests,
// checked against an in-bench key derivation. Depends on rskd_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

   localparam int IDLE_LIMIT = 20000000;
   localparam int SETTLE_CYCLES = 50;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rskd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rskd_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic              csr_wr_data = 1'b0;

   // Bench copy of the register and of the keys still owed by the core.
   bit                advance_mode = 1'b1;
   rskd_pkg::rsp_type pending_keys[$];
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                quiet = 1'b0;
   int                stall_hold = 0;

   rsa_small_key_derivation_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Trial-division primality test.
   function automatic bit is_prime_num(longint unsigned v);
      longint unsigned i;
      if (v < 2) return 1'b0;
      for (i = 2; i * i <= v; i++) begin
         if (v % i == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic longint unsigned next_prime_num(longint unsigned v);
      while (!is_prime_num(v)) v++;
      return v;
   endfunction

   // Modular inverse by extended Euclid; zero when none exists.
   function automatic logic [31:0] inverse_mod(longint unsigned a, longint unsigned m);
      longint t, nt, tmp;
      longint unsigned r, nr, qt, rt;
      t = 0;
      nt = 1;
      r = m;
      nr = a % m;
      while (nr != 0) begin
         qt = r / nr;
         tmp = t - longint'(qt) * nt;
         t = nt;
         nt = tmp;
         rt = r - qt * nr;
         r = nr;
         nr = rt;
      end
      if (r != 1) return 32'd0;
      if (t < 0) t += longint'(m);
      return t[31:0];
   endfunction

   // Derives the key that the core should return for one request.
   function automatic rskd_pkg::rsp_type derive_key(rskd_pkg::req_type rq, bit adv);
      rskd_pkg::rsp_type k;
      longint unsigned p, q, n, phi, i;
      p = rq.prime_p;
      q = rq.prime_q;
      k = '0;
      if (adv) begin
         p = next_prime_num(p);
         q = next_prime_num(q);
      end
      n = (p * q) & 64'hFFFF_FFFF;
      phi = (((p - 1) & 64'hFFFF_FFFF) * ((q - 1) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF;
      k.modulus = n[31:0];
      k.totient_value = phi[31:0];
      if (phi >= 2) begin
         for (i = rq.search_start % phi; i < phi; i++) begin
            if (i >= 2 && is_prime_num(i) && phi % i != 0) begin
               k.public_exponent = i[31:0];
               k.key_found = 1'b1;
               break;
            end
         end
         if (k.key_found) k.private_exponent = inverse_mod(i, phi);
      end
      return k;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Result side: random stall, result check and the idle watchdog.
   always @(posedge clock) begin
      rskd_pkg::rsp_type want;
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (quiet || $urandom_range(0, 99) < 65) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(0, 3);
      end

      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_keys.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            want = pending_keys.pop_front();
            if (rsp_data.modulus !== want.modulus) begin
               $error("modulus exp %0h got %0h", want.modulus, rsp_data.modulus);
               error_count++;
            end
            if (rsp_data.totient_value !== want.totient_value) begin
               $error("totient_value exp %0h got %0h", want.totient_value,
                      rsp_data.totient_value);
               error_count++;
            end
            if (rsp_data.public_exponent !== want.public_exponent) begin
               $error("public_exponent exp %0h got %0h", want.public_exponent,
                      rsp_data.public_exponent);
               error_count++;
            end
            if (rsp_data.private_exponent !== want.private_exponent) begin
               $error("private_exponent exp %0h got %0h", want.private_exponent,
                      rsp_data.private_exponent);
               error_count++;
            end
            if (rsp_data.key_found !== want.key_found) begin
               $error("key_found exp %0b got %0b", want.key_found, rsp_data.key_found);
               error_count++;
            end
         end
      end

      // A transfer on either channel restarts the watchdog.
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("rsa_small_key_derivation_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one request and records its expected key at the transfer.
   task automatic send_request(logic [15:0] p, logic [15:0] q, logic [31:0] start);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{prime_p: p, prime_q: q, search_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_keys.push_back(derive_key(req_data, advance_mode));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers valid and waits until every owed key has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_keys.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_advance(bit value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      advance_mode = value;
   endtask

   // Extremes and special cases with the prime advance on.
   task automatic test_advance_edges();
      write_advance(1'b1);
      quiet = 1'b1;
      send_request(16'd0, 16'd0, 32'd0);
      send_request(16'd1, 16'd1, 32'd5);
      send_request(16'hFFFF, 16'hFFFF, 32'd0);
      send_request(16'hFFFF, 16'd2, 32'd1);
      send_request(16'd2, 16'd2, 32'd7);
      quiet = 1'b0;
      send_request(16'd2, 16'd3, 32'd1);
      send_request(16'd12, 16'd20, 32'hFFFF_FFFF);
   endtask

   // Factors used as given: wrapped totients, small totients, empty search range.
   task automatic test_raw_factors();
      write_advance(1'b0);
      send_request(16'd0, 16'd5, 32'hFFFF_FFFF);
      send_request(16'd0, 16'd0, 32'd0);
      send_request(16'd1, 16'd7, 32'd0);
      send_request(16'd4, 16'd6, 32'd9);
      send_request(16'd3, 16'd5, 32'd7);
      send_request(16'd2, 16'd3, 32'd1);
      send_request(16'hFFFF, 16'hFFF1, 32'd3);
      send_request(16'hAAAA, 16'h5555, 32'd0);
      send_request(16'd11, 16'd13, 32'd120);
      send_request(16'd11, 16'd13, 32'd119);
   endtask

   // Small factors with full-range start values, so the search runs anywhere below phi.
   task automatic test_random_small(int count);
      repeat (count) begin
         if ($urandom_range(0, 15) == 0) write_advance(1'($urandom_range(0, 1)));
         send_request(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                      $urandom());
      end
   endtask

   // Full-width factors with a start kept low so the exponent search stays short.
   task automatic test_random_wide(int count);
      repeat (count) begin
         if ($urandom_range(0, 7) == 0) write_advance(1'($urandom_range(0, 1)));
         send_request(16'($urandom()), 16'($urandom()), $urandom_range(0, 2000));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_advance_edges();
      test_raw_factors();
      test_random_small(40);
      drain();
      test_random_wide(20);
      test_random_small(40);
      drain();
      if (error_count == 0) begin
         $display("rsa_small_key_derivation_core: match");
      end else begin
         $display("rsa_small_key_derivation_core: mismatch");
      end
      $finish;
   end

endmodule
